/* hdl/uint32_to_decimal_ascii_unit_defines.svh */
// Assertion macros for the binary to decimal ASCII converter.
`ifndef UINT32_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define UINT32_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTH

`define U2DA_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define U2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`define U2DA_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed");

`else

`define U2DA_ASSERT_ALWAYS(lbl, clk, rst, prop)

`define U2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`define U2DA_ASSERT_AFTER_RESET(lbl, clk, rst, cons)

`endif

`endif

/* hdl/u2da_pkg.sv */
// Shared constants for the binary to decimal ASCII converter.
package u2da_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 6;
  localparam int BCD_W          = 4;
  localparam int DIGITS_DEFAULT = 10;

  // Reciprocal of ten for exact division of any 32-bit value.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

endpackage

/* hdl/u2da_cell.sv */
// One converter cell: divides by ten and shifts the remainder digit into the word.
module u2da_cell import u2da_pkg::*; #(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [VALUE_W-1:0]            up_quot,
  input  logic [DIGITS-1:0][BCD_W-1:0]  up_digits,
  input  logic [$clog2(DIGITS+1)-1:0]   up_cnt,
  input  logic [$clog2(DIGITS+1)-1:0]   up_len,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [VALUE_W-1:0]            dn_quot,
  output logic [DIGITS-1:0][BCD_W-1:0]  dn_digits,
  output logic [$clog2(DIGITS+1)-1:0]   dn_cnt,
  output logic [$clog2(DIGITS+1)-1:0]   dn_len
);

  localparam int CNT_W = $clog2(DIGITS + 1);

  logic [2*VALUE_W-1:0]           prod;
  logic [VALUE_W-1:0]             quot_next;
  logic [BCD_W-1:0]               tenq_low;
  logic [BCD_W-1:0]               digit;
  logic [DIGITS-1:0][BCD_W-1:0]   digits_next;
  logic [CNT_W-1:0]               cnt_next;
  logic [CNT_W-1:0]               len_next;

  assign prod      = (2*VALUE_W)'(up_quot) * (2*VALUE_W)'(RECIP_TEN);
  assign quot_next = VALUE_W'(prod >> RECIP_SHIFT);

  // The remainder is below ten, so four bits of the difference suffice.
  assign tenq_low = {quot_next[0], 3'b000} + {quot_next[2:0], 1'b0};
  assign digit    = up_quot[BCD_W-1:0] - tenq_low;

  always_comb begin
    for (int i = 0; i < DIGITS - 1; i++) begin
      digits_next[i] = up_digits[i+1];
    end
    digits_next[DIGITS-1] = digit;
  end

  assign cnt_next = up_cnt + CNT_W'(1);
  assign len_next = (digit != '0) ? cnt_next : up_len;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_quot   <= quot_next;
      dn_digits <= digits_next;
      dn_cnt    <= cnt_next;
      dn_len    <= len_next;
    end
  end

endmodule

/* hdl/u2da_ser.sv */
// Output serializer: sends the significant digits, most significant first.
module u2da_ser import u2da_pkg::*; #(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [DIGITS-1:0][BCD_W-1:0]  up_digits,
  input  logic [$clog2(DIGITS+1)-1:0]   up_len,
  output logic                          digit_valid,
  input  logic                          digit_ready,
  output logic [CHAR_W-1:0]             digit_char,
  output logic                          last
);

  localparam int CNT_W = $clog2(DIGITS + 1);
  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                          busy;
  logic [IDX_W-1:0]              pos;
  logic [DIGITS-1:0][BCD_W-1:0]  digs;
  logic                          sent;
  logic                          load;

  assign sent     = busy && digit_ready;
  assign up_ready = !busy || (digit_ready && pos == '0);
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (sent && pos == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digs <= up_digits;
      pos  <= IDX_W'(up_len - CNT_W'(1));
    end else if (sent) begin
      pos  <= pos - IDX_W'(1);
    end
  end

  assign digit_valid = busy;
  assign digit_char  = ASCII_ZERO + CHAR_W'(digs[pos]);
  assign last        = (pos == '0);

endmodule

/* hdl/uint32_to_decimal_ascii_unit.sv */
// Top level of the binary to decimal ASCII converter: cell chain and serializer.
//
//   channel  ports                              word
//   input    value_valid, value_ready           value (32-bit unsigned)
//   output   digit_valid, digit_ready           digit_char, last
//
// A number passes DIGITS cells, one division by ten per cell, then the
// serializer sends one character per cycle while digit_ready is high. A
// number takes the output for one character per significant digit (1 to
// DIGITS), which sets the sustained rate. Reset empties every cell and the
// serializer. A stall on the output backs up through the chain, as each cell's
// ready is combinational from the next cell; no word is dropped.
`include "uint32_to_decimal_ascii_unit_defines.svh"

module uint32_to_decimal_ascii_unit import u2da_pkg::*; #(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                value_valid,
  output logic                value_ready,
  input  logic [VALUE_W-1:0]  value,
  output logic                digit_valid,
  input  logic                digit_ready,
  output logic [CHAR_W-1:0]   digit_char,
  output logic                last
);

  localparam int CNT_W = $clog2(DIGITS + 1);

  logic [DIGITS:0]                           st_valid;
  logic [DIGITS:0]                           st_ready;
  logic [DIGITS:0][VALUE_W-1:0]              st_quot;
  logic [DIGITS:0][DIGITS-1:0][BCD_W-1:0]    st_digits;
  logic [DIGITS:0][CNT_W-1:0]                st_cnt;
  logic [DIGITS:0][CNT_W-1:0]                st_len;

  assign st_valid[0]  = value_valid;
  assign value_ready  = st_ready[0];
  assign st_quot[0]   = value;
  assign st_digits[0] = '0;
  assign st_cnt[0]    = '0;
  assign st_len[0]    = CNT_W'(1);

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    u2da_cell #(
      .DIGITS (DIGITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (st_valid[g]),
      .up_ready  (st_ready[g]),
      .up_quot   (st_quot[g]),
      .up_digits (st_digits[g]),
      .up_cnt    (st_cnt[g]),
      .up_len    (st_len[g]),
      .dn_valid  (st_valid[g+1]),
      .dn_ready  (st_ready[g+1]),
      .dn_quot   (st_quot[g+1]),
      .dn_digits (st_digits[g+1]),
      .dn_cnt    (st_cnt[g+1]),
      .dn_len    (st_len[g+1])
    );
  end

  u2da_ser #(
    .DIGITS (DIGITS)
  ) u_ser (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (st_valid[DIGITS]),
    .up_ready    (st_ready[DIGITS]),
    .up_digits   (st_digits[DIGITS]),
    .up_len      (st_len[DIGITS]),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit_char  (digit_char),
    .last        (last)
  );

  `U2DA_ASSERT_ALWAYS(a_char_is_digit, clk, rst,
    !digit_valid || (digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE))
  `U2DA_ASSERT_NEXT(a_number_unbroken, clk, rst,
    digit_valid && digit_ready && !last, digit_valid)
  `U2DA_ASSERT_AFTER_RESET(a_empty_after_reset, clk, rst, !digit_valid)

endmodule
